// File: src/fpm_pkg.sv
// Package for the foot pedal MIDI event generator: key map, USB-MIDI codes,
// the control bundle of the shared note adder. No dependencies.
package fpm_pkg;

  localparam int NOTE_KEYS   = 13;
  localparam int PRESET_KEYS = 6;
  localparam int ALL_KEYS    = NOTE_KEYS + 5 + PRESET_KEYS;
  localparam int KEY_W       = 5;
  localparam int NOTE_IW     = $clog2(NOTE_KEYS);

  localparam logic [KEY_W-1:0] OCT_KEY0      = KEY_W'(NOTE_KEYS);
  localparam logic [KEY_W-1:0] SUST_PROP_KEY = KEY_W'(NOTE_KEYS + 3);
  localparam logic [KEY_W-1:0] SUST_MIDI_KEY = KEY_W'(NOTE_KEYS + 4);
  localparam logic [KEY_W-1:0] PRESET_KEY0   = KEY_W'(NOTE_KEYS + 5);
  localparam logic [KEY_W-1:0] KEY_LIMIT     = KEY_W'(ALL_KEYS);

  localparam logic [3:0] CIN_NOTE   = 4'h9;
  localparam logic [7:0] ST_NOTE    = 8'h91;
  localparam logic [3:0] CIN_CC     = 4'hB;
  localparam logic [7:0] ST_CC      = 8'hB1;
  localparam logic [3:0] CIN_PC     = 4'hC;
  localparam logic [7:0] ST_PC      = 8'hC1;
  localparam logic [6:0] CC_SUSTAIN = 7'd64;
  localparam logic [6:0] VEL_ON     = 7'd127;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_PROP = 2'd1;
  localparam logic [1:0] MODE_MIDI = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [1:0] OCT_MID  = 2'd0;
  localparam logic [1:0] OCT_HIGH = 2'd1;
  localparam logic [1:0] OCT_BAD  = 2'd2;
  localparam logic [1:0] OCT_LOW  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       use_acc;
  } add_ctrl_t;

endpackage

// File: src/fpm_note_adder.sv
// Shared 7-bit note adder with accumulator and held-note compare.
// Depends on fpm_pkg for the control bundle.
module fpm_note_adder import fpm_pkg::*; (
  input  logic      clk,
  input  add_ctrl_t ctrl,
  input  logic [6:0] opa,
  input  logic [6:0] opb,
  input  logic [6:0] cmp,
  output logic [6:0] acc,
  output logic       eq
);

  logic [6:0] acc_r;
  logic [6:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = (ctrl.use_acc ? acc_r : opa) + opb;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;
  assign eq  = (acc_r == cmp);

endmodule

// File: src/foot_pedal_midi_event_generator.sv
// Top level of the foot pedal MIDI event generator: sequencer, key state,
// output register. Depends on fpm_pkg and fpm_note_adder.
//
//  channel | ports                                        | handshake
//  input   | in_button, in_level                          | in_valid / in_ready
//  output  | out_code_index, out_status_byte, out_data_*  | out_valid / out_ready
//  config  | cfg_wr_data (base note)                      | cfg_wr_en, no wait
//
// A sustain-prop press sends a note-off for every note key, one beat per note
// key. One shared 7-bit adder forms the note, first base note plus key, then
// plus the octave offset; messages leave one a cycle through a single output
// register, and a stalled out_ready holds the sequencer. in_ready is high
// only while idle.
// Reset is synchronous, active low, and clears all key and mode state.
module foot_pedal_midi_event_generator import fpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KEY_W-1:0] in_button,
  input  logic             in_level,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_code_index,
  output logic [7:0]       out_status_byte,
  output logic [6:0]       out_data_one,
  output logic [6:0]       out_data_two,
  output logic             out_last,
  input  logic             cfg_wr_en,
  input  logic [5:0]       cfg_wr_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_ADD2   = 3'd2;
  localparam logic [2:0] S_NOTE   = 3'd3;
  localparam logic [2:0] S_NOTEON = 3'd4;
  localparam logic [2:0] S_SWEEP  = 3'd5;
  localparam logic [2:0] S_CCON   = 3'd6;
  localparam logic [2:0] S_CCOFF  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               press_r, press_nxt;
  logic               rel_r, rel_nxt;
  logic [NOTE_IW-1:0] cnt_r, cnt_nxt;
  logic [5:0]         base_r, base_nxt;
  logic [ALL_KEYS-1:0] prev_r, prev_nxt;
  logic [6:0]         kln_r [NOTE_KEYS];
  logic               kln_we;
  logic [6:0]         held_r, held_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               gate_r, gate_nxt;
  logic [1:0]         oct_r, oct_nxt;

  logic               ov_r, ov_nxt;
  logic [3:0]         cin_r, cin_nxt;
  logic [7:0]         st_r, st_nxt;
  logic [6:0]         d1_r, d1_nxt;
  logic [6:0]         d2_r, d2_nxt;
  logic               last_r, last_nxt;

  add_ctrl_t          actl;
  logic [6:0]         add_b;
  logic [6:0]         acc;
  logic               acc_eq;
  logic [NOTE_IW-1:0] rd_idx;
  logic [6:0]         rd_note;
  logic [6:0]         oct_off;
  logic               emit_ok;
  logic               in_fire;
  logic [KEY_W-1:0]   preset_idx;

  fpm_note_adder u_adder (
    .clk  (clk),
    .ctrl (actl),
    .opa  ({1'b0, base_r}),
    .opb  (add_b),
    .cmp  (held_r),
    .acc  (acc),
    .eq   (acc_eq)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign emit_ok    = !ov_r || out_ready;
  assign rd_idx     = (state_r == S_SWEEP) ? cnt_r : key_r[NOTE_IW-1:0];
  assign rd_note    = kln_r[rd_idx];
  assign preset_idx = key_r - PRESET_KEY0;

  always_comb begin
    unique case (oct_r)
      OCT_MID:  oct_off = 7'd0;
      OCT_HIGH: oct_off = 7'd12;
      OCT_BAD:  oct_off = 7'd104;
      OCT_LOW:  oct_off = 7'd116;
      default:  oct_off = 7'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    press_nxt = press_r;
    rel_nxt   = rel_r;
    cnt_nxt   = cnt_r;
    base_nxt  = cfg_wr_en ? cfg_wr_data : base_r;
    prev_nxt  = prev_r;
    kln_we    = 1'b0;
    held_nxt  = held_r;
    mode_nxt  = mode_r;
    gate_nxt  = gate_r;
    oct_nxt   = oct_r;
    ov_nxt    = ov_r && !out_ready;
    cin_nxt   = cin_r;
    st_nxt    = st_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    last_nxt  = last_r;
    actl      = '{load: 1'b0, use_acc: 1'b0};
    add_b     = {2'b00, key_r};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_button < KEY_LIMIT) begin
          key_nxt   = in_button;
          press_nxt = !in_level && prev_r[in_button];
          rel_nxt   = in_level && !prev_r[in_button];
          prev_nxt[in_button] = in_level;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (key_r < OCT_KEY0) begin
          if (press_r) begin
            actl      = '{load: 1'b1, use_acc: 1'b0};
            state_nxt = S_ADD2;
          end else if (rel_r && mode_r != MODE_PROP) begin
            if (emit_ok) begin
              ov_nxt = 1'b1; cin_nxt = CIN_NOTE; st_nxt = ST_NOTE;
              d1_nxt = rd_note; d2_nxt = 7'd0; last_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (key_r < SUST_PROP_KEY) begin
          if (press_r) begin
            if (key_r == OCT_KEY0) oct_nxt = OCT_LOW;
            else if (key_r == OCT_KEY0 + KEY_W'(1)) oct_nxt = OCT_MID;
            else oct_nxt = OCT_HIGH;
          end
          state_nxt = S_IDLE;
        end else if (key_r == SUST_PROP_KEY) begin
          cnt_nxt   = '0;
          state_nxt = press_r ? S_SWEEP : S_IDLE;
        end else if (key_r == SUST_MIDI_KEY) begin
          state_nxt = S_IDLE;
          if (press_r) begin
            if (mode_r == MODE_NONE || mode_r == MODE_PROP) begin
              gate_nxt  = 1'b1;
              mode_nxt  = MODE_MIDI;
              state_nxt = S_CCON;
            end else if (mode_r == MODE_MIDI) begin
              mode_nxt  = MODE_NONE;
              state_nxt = S_CCOFF;
            end
          end
        end else begin
          if (!press_r) begin
            state_nxt = S_IDLE;
          end else if (emit_ok) begin
            ov_nxt = 1'b1; cin_nxt = CIN_PC; st_nxt = ST_PC;
            d1_nxt = {2'b00, preset_idx}; d2_nxt = 7'd0; last_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADD2: begin
        actl      = '{load: 1'b1, use_acc: 1'b1};
        add_b     = oct_off;
        state_nxt = S_NOTE;
      end
      S_NOTE: begin
        if (mode_r == MODE_PROP && !acc_eq) begin
          if (emit_ok) begin
            ov_nxt = 1'b1; cin_nxt = CIN_NOTE; st_nxt = ST_NOTE;
            d1_nxt = held_r; d2_nxt = 7'd0; last_nxt = 1'b0;
            kln_we    = 1'b1;
            held_nxt  = acc;
            gate_nxt  = 1'b1;
            state_nxt = S_NOTEON;
          end
        end else begin
          kln_we = 1'b1;
          if (mode_r == MODE_PROP) gate_nxt = !gate_r;
          state_nxt = S_NOTEON;
        end
      end
      S_NOTEON: begin
        if (emit_ok) begin
          ov_nxt = 1'b1; cin_nxt = CIN_NOTE; st_nxt = ST_NOTE;
          d1_nxt = acc; d2_nxt = gate_r ? VEL_ON : 7'd0; last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (emit_ok) begin
          ov_nxt = 1'b1; cin_nxt = CIN_NOTE; st_nxt = ST_NOTE;
          d1_nxt = rd_note; d2_nxt = 7'd0;
          last_nxt = (cnt_r == NOTE_IW'(NOTE_KEYS - 1)) && (mode_r != MODE_MIDI);
          cnt_nxt  = cnt_r + NOTE_IW'(1);
          if (cnt_r == NOTE_IW'(NOTE_KEYS - 1)) begin
            state_nxt = S_IDLE;
            if (mode_r == MODE_MIDI || mode_r == MODE_NONE) begin
              held_nxt = 7'd0;
              mode_nxt = MODE_PROP;
              if (mode_r == MODE_MIDI) state_nxt = S_CCOFF;
            end else if (mode_r == MODE_PROP) begin
              gate_nxt = 1'b1;
              mode_nxt = MODE_NONE;
            end
          end
        end
      end
      S_CCON, S_CCOFF: begin
        if (emit_ok) begin
          ov_nxt = 1'b1; cin_nxt = CIN_CC; st_nxt = ST_CC;
          d1_nxt = CC_SUSTAIN; d2_nxt = (state_r == S_CCON) ? VEL_ON : 7'd0;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= 6'd48;
      prev_r  <= '0;
      held_r  <= '0;
      mode_r  <= MODE_NONE;
      gate_r  <= 1'b1;
      oct_r   <= OCT_MID;
      ov_r    <= 1'b0;
      for (int i = 0; i < NOTE_KEYS; i++) kln_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      prev_r  <= prev_nxt;
      held_r  <= held_nxt;
      mode_r  <= mode_nxt;
      gate_r  <= gate_nxt;
      oct_r   <= oct_nxt;
      ov_r    <= ov_nxt;
      if (kln_we) kln_r[key_r[NOTE_IW-1:0]] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    press_r <= press_nxt;
    rel_r   <= rel_nxt;
    cnt_r   <= cnt_nxt;
    cin_r   <= cin_nxt;
    st_r    <= st_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_code_index  = cin_r;
  assign out_status_byte = st_r;
  assign out_data_one    = d1_r;
  assign out_data_two    = d2_r;
  assign out_last        = last_r;

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_BAD) else $error("sustain mode reached unused code");

  a_oct_legal: assert property (@(posedge clk) disable iff (!rst_n)
    oct_r != OCT_BAD) else $error("octave reached unused code");

  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> cnt_r < NOTE_IW'(NOTE_KEYS)) else $error("sweep past last key");

  a_add_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD2 |-> $past(state_r) == S_DISP) else $error("adder step out of order");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP |-> key_r < KEY_LIMIT) else $error("dispatch of unknown key");

endmodule

// File: tb/tb_foot_pedal_midi_event_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for foot_pedal_midi_event_generator: pedal level beats
// go in through a queue-fed driver, a beat-level predictor of the MIDI messages
// checks every output beat. Depends on fpm_pkg and the generator RTL.
module tb_foot_pedal_midi_event_generator;
  import fpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CHOKE_CYCLES   = 300;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic       last;
  } midi_msg_t;

  typedef struct packed {
    logic [KEY_W-1:0] button;
    logic             level;
  } pedal_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [KEY_W-1:0] in_button = '0;
  logic             in_level = 1'b1;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [3:0]       out_code_index;
  logic [7:0]       out_status_byte;
  logic [6:0]       out_data_one;
  logic [6:0]       out_data_two;
  logic             out_last;
  logic             cfg_wr_en = 1'b0;
  logic [5:0]       cfg_wr_data = 6'd48;

  // predicted pedal state
  logic [ALL_KEYS-1:0] pin_prev;
  logic [6:0]          key_note [NOTE_KEYS];
  logic [6:0]          held_note;
  logic [1:0]          sus_mode;
  logic                gate;
  logic [1:0]          octave;
  logic [5:0]          base_note;

  midi_msg_t   midi_expected [$];
  pedal_beat_t pending_beats [$];
  logic        gen_level [32];
  int          batch_len;
  int          pushed_cnt = 0;
  int          beats_taken = 0;
  int          err_count = 0;
  int          idle_cycles = 0;
  int          send_wait = 0;
  int          hold_left = 0;
  int          choke_asked = 0;
  int          choke_seen = 0;
  logic        calm = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  foot_pedal_midi_event_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_button      (in_button),
    .in_level       (in_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_index (out_code_index),
    .out_status_byte(out_status_byte),
    .out_data_one   (out_data_one),
    .out_data_two   (out_data_two),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic reset_pedal_state();
    int k;
    pin_prev  = '0;
    for (k = 0; k < NOTE_KEYS; k++) key_note[k] = 7'd0;
    held_note = 7'd0;
    sus_mode  = MODE_NONE;
    gate      = 1'b1;
    octave    = OCT_MID;
    base_note = 6'd48;
  endtask

  task automatic push_msg(logic [3:0] cin, logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    midi_expected.push_back({cin, st, d1, d2, 1'b0});
    batch_len++;
  endtask

  task automatic apply_pedal_event(logic [KEY_W-1:0] b, logic lvl);
    int        key;
    int        k;
    int        shift;
    int        sum;
    logic      press;
    logic      rel;
    logic [6:0] note;
    midi_msg_t m;
    batch_len = 0;
    if (b < KEY_LIMIT) begin
      key   = b;
      press = !lvl && pin_prev[key];
      rel   = lvl && !pin_prev[key];
      pin_prev[key] = lvl;
      if (key < NOTE_KEYS) begin
        if (press) begin
          case (octave)
            OCT_LOW:  shift = -12;
            OCT_HIGH: shift = 12;
            OCT_BAD:  shift = -24;
            default:  shift = 0;
          endcase
          sum  = int'(base_note) + key + shift;
          note = sum[6:0];
          key_note[key] = note;
          if (sus_mode == MODE_PROP) begin
            if (held_note != note) begin
              push_msg(CIN_NOTE, ST_NOTE, held_note, 7'd0);
              held_note = note;
              gate      = 1'b1;
            end else begin
              gate = ~gate;
            end
          end
          push_msg(CIN_NOTE, ST_NOTE, note, gate ? VEL_ON : 7'd0);
        end else if (rel && sus_mode != MODE_PROP) begin
          push_msg(CIN_NOTE, ST_NOTE, key_note[key], 7'd0);
        end
      end else if (key < SUST_PROP_KEY) begin
        if (press) begin
          if (key == OCT_KEY0) octave = OCT_LOW;
          else if (key == OCT_KEY0 + 1) octave = OCT_MID;
          else octave = OCT_HIGH;
        end
      end else if (key == SUST_PROP_KEY) begin
        if (press) begin
          for (k = 0; k < NOTE_KEYS; k++) push_msg(CIN_NOTE, ST_NOTE, key_note[k], 7'd0);
          if (sus_mode == MODE_MIDI || sus_mode == MODE_NONE) begin
            if (sus_mode == MODE_MIDI) push_msg(CIN_CC, ST_CC, CC_SUSTAIN, 7'd0);
            held_note = 7'd0;
            sus_mode  = MODE_PROP;
          end else if (sus_mode == MODE_PROP) begin
            gate     = 1'b1;
            sus_mode = MODE_NONE;
          end
        end
      end else if (key == SUST_MIDI_KEY) begin
        if (press) begin
          if (sus_mode == MODE_NONE || sus_mode == MODE_PROP) begin
            gate = 1'b1;
            push_msg(CIN_CC, ST_CC, CC_SUSTAIN, VEL_ON);
            sus_mode = MODE_MIDI;
          end else if (sus_mode == MODE_MIDI) begin
            push_msg(CIN_CC, ST_CC, CC_SUSTAIN, 7'd0);
            sus_mode = MODE_NONE;
          end
        end
      end else if (press) begin
        push_msg(CIN_PC, ST_PC, 7'(key - PRESET_KEY0), 7'd0);
      end
    end
    if (batch_len > 0) begin
      m = midi_expected.pop_back();
      m.last = 1'b1;
      midi_expected.push_back(m);
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    if (err_count < PRINT_LIMIT)
      $display("%0t mismatch %s: expected 0x%0h got 0x%0h", $realtime, what, want, got);
    err_count++;
  endtask

  task automatic check_field(string what, int want, int got);
    if (want != got) report_mismatch(what, want, got);
  endtask

  // predict on input beats, check output beats, watchdog
  always @(posedge clk) begin
    midi_msg_t got;
    midi_msg_t want;
    if (!rst_n) begin
      reset_pedal_state();
      in_fire     <= 1'b0;
      out_fire    <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_fire  <= in_valid && in_ready;
      out_fire <= out_valid && out_ready;
      if (cfg_wr_en) base_note = cfg_wr_data;
      if (in_valid && in_ready) begin
        apply_pedal_event(in_button, in_level);
        beats_taken++;
      end
      if (out_valid && out_ready) begin
        got = {out_code_index, out_status_byte, out_data_one, out_data_two, out_last};
        if (midi_expected.size() == 0) begin
          report_mismatch("unexpected message", 0, got);
        end else begin
          want = midi_expected.pop_front();
          check_field("code_index", want.code_index, got.code_index);
          check_field("status_byte", want.status_byte, got.status_byte);
          check_field("data_one", want.data_one, got.data_one);
          check_field("data_two", want.data_two, got.data_two);
          check_field("last", want.last, got.last);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $realtime, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    pedal_beat_t nxt;
    int          gap;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_fire) begin
      gap = send_wait;
      if (in_valid) gap = calm ? 0 : $urandom_range(0, 9);
      if (gap == 0 && pending_beats.size() > 0) begin
        nxt = pending_beats.pop_front();
        in_button <= nxt.button;
        in_level  <= nxt.level;
        in_valid  <= 1'b1;
      end else begin
        in_valid  <= 1'b0;
        send_wait <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (choke_seen != choke_asked) begin
      choke_seen <= choke_asked;
      out_ready  <= 1'b0;
      hold_left  <= CHOKE_CYCLES;
    end else begin
      stall = hold_left;
      if (out_fire && hold_left == 0) stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        hold_left <= stall - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_beat(logic [KEY_W-1:0] b, logic lvl);
    pending_beats.push_back({b, lvl});
    gen_level[b] = lvl;
    pushed_cnt++;
  endtask

  task automatic wait_idle();
    while (beats_taken != pushed_cnt || midi_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(logic [5:0] value);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  task automatic random_beats(int count);
    int               made;
    int               r;
    logic [KEY_W-1:0] b;
    logic             lvl;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 58) b = KEY_W'($urandom_range(0, NOTE_KEYS - 1));
      else if (r < 68) b = KEY_W'($urandom_range(OCT_KEY0, OCT_KEY0 + 2));
      else if (r < 74) b = SUST_PROP_KEY;
      else if (r < 80) b = SUST_MIDI_KEY;
      else if (r < 96) b = KEY_W'($urandom_range(PRESET_KEY0, ALL_KEYS - 1));
      else b = KEY_W'($urandom_range(ALL_KEYS, 31));
      // mostly clean press/release alternation, some repeated levels
      lvl = ($urandom_range(0, 9) < 8) ? ~gen_level[b] : 1'($urandom_range(0, 1));
      made++;
      queue_beat(b, lvl);
    end
  endtask

  task automatic run_phase(logic [5:0] base, int count, logic quiet, logic choke);
    wait_idle();
    write_base(base);
    calm = quiet;
    if (choke) choke_asked++;
    random_beats(count);
  endtask

  initial begin
    int k;
    for (k = 0; k < 32; k++) gen_level[k] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    write_base(6'd48);

    // power-up release, plain press/release, octave low
    queue_beat(5'd0, 1'b1);
    queue_beat(5'd0, 1'b0);
    queue_beat(5'd0, 1'b1);
    queue_beat(OCT_KEY0, 1'b1);
    queue_beat(OCT_KEY0, 1'b0);
    queue_beat(5'd12, 1'b1);
    queue_beat(5'd12, 1'b0);
    // enter proportional sustain, latch a note, toggle it off
    queue_beat(SUST_PROP_KEY, 1'b1);
    queue_beat(SUST_PROP_KEY, 1'b0);
    queue_beat(5'd5, 1'b1);
    queue_beat(5'd5, 1'b0);
    queue_beat(5'd5, 1'b1);
    queue_beat(5'd5, 1'b0);
    // leave prop, midi sustain on, prop from midi (longest burst), midi from prop
    queue_beat(SUST_PROP_KEY, 1'b1);
    queue_beat(SUST_PROP_KEY, 1'b0);
    queue_beat(SUST_MIDI_KEY, 1'b1);
    queue_beat(SUST_MIDI_KEY, 1'b0);
    queue_beat(SUST_PROP_KEY, 1'b1);
    queue_beat(SUST_PROP_KEY, 1'b0);
    queue_beat(SUST_MIDI_KEY, 1'b1);
    queue_beat(SUST_MIDI_KEY, 1'b0);
    // first and last preset, buttons out of range
    queue_beat(PRESET_KEY0, 1'b1);
    queue_beat(PRESET_KEY0, 1'b0);
    queue_beat(KEY_LIMIT - 5'd1, 1'b1);
    queue_beat(KEY_LIMIT - 5'd1, 1'b0);
    queue_beat(5'd31, 1'b0);
    queue_beat(KEY_LIMIT, 1'b1);

    run_phase(6'd59, 100, 1'b0, 1'b0);
    run_phase(6'd0, 70, 1'b1, 1'b0);
    run_phase(6'd63, 100, 1'b0, 1'b1);
    run_phase(6'($urandom_range(48, 59)), 90, 1'b0, 1'b0);
    run_phase(6'($urandom_range(48, 59)), 90, 1'b0, 1'b0);

    wait_idle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
